// ===== sv/itrd_pkg.sv =====
// Shared types, constants and the digit character table for the radix digit converter.
package itrd_pkg;

    localparam int VALUE_W    = 64;
    localparam int BASE_W     = 5;
    localparam int DIG_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int MAX_DIGITS = 64;
    localparam int BYTES      = VALUE_W / BYTE_W;
    localparam int IDX_W      = $clog2(BYTES);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int S_TDATA_W  = ((VALUE_W + BASE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((CHAR_W + 7) / 8) * 8;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] DIGIT_SET [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic [DIG_W-1:0]  rem;
        logic [BYTE_W-1:0] dvd;
        logic [BASE_W-1:0] base;
    } t_div_req;

    typedef struct packed {
        logic [BYTE_W-1:0] quo;
        logic [DIG_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DIG_W-1:0]  wr_digit;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_stack_req;

endpackage

// ===== sv/itrd_div_step.sv =====
// Shared divide unit: one dividend byte with running remainder over a base of 2 to 16.
module itrd_div_step
    import itrd_pkg::*;
(
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIG_W:0]    part;
    logic [BYTE_W-1:0] quo;

    always_comb begin
        part = {1'b0, i_req.rem};
        quo  = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            part = {part[DIG_W-1:0], i_req.dvd[b]};
            if (part >= i_req.base) begin
                part   = part - i_req.base;
                quo[b] = 1'b1;
            end
        end
        o_rsp.quo = quo;
        o_rsp.rem = part[DIG_W-1:0];
    end

endmodule

// ===== sv/itrd_digit_stack.sv =====
// Digit store: remainders written least significant first, read back in reverse.
module itrd_digit_stack
    import itrd_pkg::*;
(
    input  logic             i_clk,
    input  t_stack_req       i_req,
    output logic [DIG_W-1:0] o_rd_digit
);

    logic [DIG_W-1:0] r_mem [MAX_DIGITS];
    logic [DIG_W-1:0] r_rd_digit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_digit <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_digit = r_rd_digit;

endmodule

// ===== sv/itrd_ctrl.sv =====
// Sequencer: byte-serial long division per digit, digit store control and output register.
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic               i_func,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [BASE_W-1:0]  i_base,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    output t_stack_req         o_stack_req,
    input  logic [DIG_W-1:0]   i_rd_digit,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [CHAR_W-1:0]  o_char,
    output logic               o_minus,
    output logic               o_last
);

    t_state                        r_state, n_state;
    logic [BYTES-1:0][BYTE_W-1:0]  r_mag, n_mag;
    logic [BASE_W-1:0]             r_base, n_base;
    logic [IDX_W-1:0]              r_len, n_len;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [DIG_W-1:0]              r_rem, n_rem;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [ADDR_W-1:0]             r_ptr, n_ptr;
    logic                          r_first, n_first;
    logic                          r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]             r_out_char, n_out_char;
    logic                          r_out_minus, n_out_minus;
    logic                          r_out_last, n_out_last;

    logic                          s_accept;
    logic                          slot_free;
    logic                          neg_in;
    logic [VALUE_W-1:0]            mag_in;
    logic [BYTES-1:0][BYTE_W-1:0]  mag_bytes;
    logic [IDX_W-1:0]              top_in;
    logic                          mag_zero;
    logic                          top_zero;

    assign o_s_ready = (r_state == ST_IDLE);
    assign s_accept  = i_s_valid && o_s_ready;
    assign slot_free = !r_out_valid || i_m_ready;

    assign neg_in    = i_func && i_value[VALUE_W-1];
    assign mag_in    = neg_in ? (VALUE_W'(0) - i_value) : i_value;
    assign mag_bytes = mag_in;

    always_comb begin
        top_in = '0;
        for (int b = 1; b < BYTES; b++) begin
            if (mag_bytes[b] != '0) begin
                top_in = IDX_W'(b);
            end
        end
    end

    // quotient is zero once its only significant byte divides to zero
    assign mag_zero = (r_len == '0) && (i_div_rsp.quo == '0);
    assign top_zero = (r_len != '0) && (r_mag[r_len] == '0);

    assign o_div_req = '{rem: r_rem, dvd: r_mag[r_idx], base: r_base};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_idx == '0 && mag_zero) begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (slot_free) begin
                    n_state = (r_ptr == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_mag       = r_mag;
        n_base      = r_base;
        n_len       = r_len;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out_char  = r_out_char;
        n_out_minus = r_out_minus;
        n_out_last  = r_out_last;
        o_stack_req = '{wr_en: 1'b0, wr_addr: r_cnt[ADDR_W-1:0], wr_digit: i_div_rsp.rem,
                        rd_en: 1'b0, rd_addr: r_ptr};
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_mag   = mag_bytes;
                    n_first = neg_in;
                    n_len   = top_in;
                    n_idx   = top_in;
                    n_rem   = '0;
                    n_cnt   = '0;
                    if (i_base < BASE_MIN) begin
                        n_base = BASE_MIN;
                    end else if (i_base > BASE_MAX) begin
                        n_base = BASE_MAX;
                    end else begin
                        n_base = i_base;
                    end
                end
            end
            ST_DIV: begin
                n_mag[r_idx] = i_div_rsp.quo;
                if (r_idx != '0) begin
                    n_idx = r_idx - IDX_W'(1);
                    n_rem = i_div_rsp.rem;
                end else begin
                    o_stack_req.wr_en = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    n_rem = '0;
                    n_ptr = r_cnt[ADDR_W-1:0];
                    if (top_zero) begin
                        n_len = r_len - IDX_W'(1);
                        n_idx = r_len - IDX_W'(1);
                    end else begin
                        n_idx = r_len;
                    end
                end
            end
            ST_EMIT_RD: begin
                o_stack_req.rd_en = 1'b1;
            end
            ST_EMIT_LD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = DIGIT_SET[i_rd_digit];
                    n_out_minus = r_first;
                    n_out_last  = (r_ptr == '0);
                    n_first     = 1'b0;
                    if (r_ptr != '0) begin
                        n_ptr = r_ptr - ADDR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_base      <= n_base;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_ptr       <= n_ptr;
        r_first     <= n_first;
        r_out_char  <= n_out_char;
        r_out_minus <= n_out_minus;
        r_out_last  <= n_out_last;
    end

    assign o_m_valid = r_out_valid;
    assign o_char    = r_out_char;
    assign o_minus   = r_out_minus;
    assign o_last    = r_out_last;

endmodule

// ===== sv/integer_to_radix_digits_unit.sv =====
// Top level: 64-bit integer to ASCII digits in base 2 to 16, most significant digit first.
//
//  channel  | dir | tdata                               | tuser       | tlast
//  s_axis   | in  | [63:0] value, [68:64] base, zeros   | func        | -
//  m_axis   | out | [6:0] digit_char, zero              | minus_sign  | last
//
// Each digit is found by dividing the significant bytes of the current magnitude (1 to 8) in
// the shared byte divide unit, one byte per cycle; each digit is then read from the digit store.
// Reset (synchronous, active low) clears the sequencer and output valid; no clearing pass.
// s_axis is not ready from a transaction until the last digit reaches the output register;
// a stalled m_axis holds the output register and pauses readback.
module integer_to_radix_digits_unit
    import itrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // value[63:0], base[68:64], zero pad
    input  logic                 i_s_axis_tuser,   // func
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // digit_char[6:0], zero pad
    output logic                 o_m_axis_tuser,   // minus_sign
    output logic                 o_m_axis_tlast
);

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_stack_req        stack_req;
    logic [DIG_W-1:0]  rd_digit;
    logic [CHAR_W-1:0] out_char;

    itrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata[VALUE_W-1:0]),
        .i_base      (i_s_axis_tdata[VALUE_W+BASE_W-1:VALUE_W]),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_stack_req (stack_req),
        .i_rd_digit  (rd_digit),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_char      (out_char),
        .o_minus     (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

    itrd_div_step u_div (
        .i_req (div_req),
        .o_rsp (div_rsp)
    );

    itrd_digit_stack u_stack (
        .i_clk      (i_clk),
        .i_req      (stack_req),
        .o_rd_digit (rd_digit)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - CHAR_W){1'b0}}, out_char};

endmodule

// ===== sv/itrd_checker.sv =====
// Port-level checker for the radix digit converter, bound to the top level.
module itrd_checker
    import itrd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 i_s_tready,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata,
    input logic                 i_m_tuser,
    input logic                 i_m_tlast
);

    logic r_mid;

    // set between the first and the last digit transaction of one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (i_m_tvalid && i_m_tready) begin
            r_mid <= !i_m_tlast;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("ready right after an input transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast)))
        else $error("stalled output changed");

    a_minus_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid && i_m_tvalid) |-> !i_m_tuser)
        else $error("minus flag past the first digit");

    // the last digit may wait in the output register while the next input is taken
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid && !(i_m_tvalid && i_m_tlast)) |-> !i_s_tready)
        else $error("input ready while digits remain");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);
